>>> rtl/core/cnpp_pkg.sv
`timescale 1ns / 1ps

package cnpp_pkg;

	// screen geometry
	localparam int SCREEN_SIDE = 128;
	localparam int STORE_DEPTH = SCREEN_SIDE * SCREEN_SIDE;
	localparam int SIDE_W      = $clog2(SCREEN_SIDE);
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	// field widths
	localparam int OP_W    = 2;
	localparam int COORD_W = 9;
	localparam int CAM_W   = 8;
	localparam int CLIP_W  = 8;
	localparam int COLOR_W = 4;
	localparam int MASK_W  = 1 << COLOR_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = MASK_W;

	// wide enough for coordinate plus camera, and for the clip edge sums
	localparam int EXT_W = COORD_W + 2;

	// reset values of the clip size registers
	localparam logic [CLIP_W-1:0] CLIP_SIZE_RST = CLIP_W'(128);

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_W     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_H     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TRANS_MASK = 3'd6;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_FILL,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic fill_wr;
		logic fill_zero;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_clear;
		logic fill_last;
	} dp_status_t;

endpackage

>>> rtl/core/cnpp_ctrl.sv
`timescale 1ns / 1ps

module cnpp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  cnpp_pkg::dp_status_t  status,
	output cnpp_pkg::ctrl_cmd_t   cmd
);

	cnpp_pkg::state_t state_q;
	cnpp_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cnpp_pkg::ST_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			cnpp_pkg::ST_INIT: begin
				if (status.fill_last) state_nxt = cnpp_pkg::ST_IDLE;
			end
			cnpp_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = cnpp_pkg::ST_EXEC;
			end
			cnpp_pkg::ST_EXEC: begin
				state_nxt = status.is_clear ? cnpp_pkg::ST_FILL : cnpp_pkg::ST_OUT;
			end
			cnpp_pkg::ST_FILL: begin
				if (status.fill_last) state_nxt = cnpp_pkg::ST_OUT;
			end
			cnpp_pkg::ST_OUT: begin
				if (!out_stall) state_nxt = cnpp_pkg::ST_IDLE;
			end
			default: state_nxt = cnpp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall      = 1'b1;
		out_valid     = 1'b0;
		cmd.capture   = 1'b0;
		cmd.exec      = 1'b0;
		cmd.fill_wr   = 1'b0;
		cmd.fill_zero = 1'b0;
		unique case (state_q)
			cnpp_pkg::ST_INIT: begin
				cmd.fill_wr   = 1'b1;
				cmd.fill_zero = 1'b1;
			end
			cnpp_pkg::ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			cnpp_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			cnpp_pkg::ST_FILL: begin
				cmd.fill_wr = 1'b1;
			end
			cnpp_pkg::ST_OUT: begin
				out_valid = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

>>> rtl/core/cnpp_datapath.sv
`timescale 1ns / 1ps

module cnpp_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [cnpp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [cnpp_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic [cnpp_pkg::OP_W-1:0]             operation,
	input  logic signed [cnpp_pkg::COORD_W-1:0]   coord_x,
	input  logic signed [cnpp_pkg::COORD_W-1:0]   coord_y,
	input  logic [cnpp_pkg::COLOR_W-1:0]          pixel_color,
	output logic [cnpp_pkg::COLOR_W-1:0]          read_color,
	output logic                                  was_written,
	input  cnpp_pkg::ctrl_cmd_t                   cmd,
	output cnpp_pkg::dp_status_t                  status
);

	localparam int EXT_W  = cnpp_pkg::EXT_W;
	localparam int ADDR_W = cnpp_pkg::ADDR_W;
	localparam int SIDE_W = cnpp_pkg::SIDE_W;

	// configuration registers
	logic signed [cnpp_pkg::CAM_W-1:0]  cam_x_q;
	logic signed [cnpp_pkg::CAM_W-1:0]  cam_y_q;
	logic [cnpp_pkg::CLIP_W-1:0]        clip_left_q;
	logic [cnpp_pkg::CLIP_W-1:0]        clip_top_q;
	logic [cnpp_pkg::CLIP_W-1:0]        clip_w_q;
	logic [cnpp_pkg::CLIP_W-1:0]        clip_h_q;
	logic [cnpp_pkg::MASK_W-1:0]        mask_q;

	// captured item
	cnpp_pkg::op_t                      op_q;
	logic signed [cnpp_pkg::COORD_W-1:0] x_q;
	logic signed [cnpp_pkg::COORD_W-1:0] y_q;
	logic [cnpp_pkg::COLOR_W-1:0]       color_q;

	// result registers
	logic                               wr_flag_q;
	logic                               rd_hit_q;
	logic [cnpp_pkg::COLOR_W-1:0]       rd_data_q;

	logic [ADDR_W-1:0]                  cnt_q;
	logic [cnpp_pkg::COLOR_W-1:0]       mem [cnpp_pkg::STORE_DEPTH];

	logic signed [EXT_W-1:0] wx;
	logic signed [EXT_W-1:0] wy;
	logic signed [EXT_W-1:0] rx;
	logic signed [EXT_W-1:0] ry;
	logic signed [EXT_W-1:0] clip_l;
	logic signed [EXT_W-1:0] clip_t;
	logic signed [EXT_W-1:0] clip_r;
	logic signed [EXT_W-1:0] clip_b;
	logic                    in_clip;
	logic                    w_on_screen;
	logic                    r_on_screen;
	logic                    opaque;
	logic                    wr_ok;
	logic                    mem_we;
	logic                    mem_re;
	logic [ADDR_W-1:0]       mem_addr;
	logic [cnpp_pkg::COLOR_W-1:0] mem_wdata;

	function automatic logic on_screen(logic signed [EXT_W-1:0] px,
	                                   logic signed [EXT_W-1:0] py);
		logic signed [EXT_W-1:0] side;
		side = EXT_W'(cnpp_pkg::SCREEN_SIDE);
		return (px >= 0) && (px < side) && (py >= 0) && (py < side);
	endfunction

	// row major: y * side + x
	function automatic logic [ADDR_W-1:0] pix_addr(logic signed [EXT_W-1:0] px,
	                                                logic signed [EXT_W-1:0] py);
		return ADDR_W'(py[SIDE_W-1:0]) * ADDR_W'(cnpp_pkg::SCREEN_SIDE)
		     + ADDR_W'(px[SIDE_W-1:0]);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q     <= '0;
			cam_y_q     <= '0;
			clip_left_q <= '0;
			clip_top_q  <= '0;
			clip_w_q    <= cnpp_pkg::CLIP_SIZE_RST;
			clip_h_q    <= cnpp_pkg::CLIP_SIZE_RST;
			mask_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cnpp_pkg::REG_CAMERA_X:   cam_x_q     <= cfg_data[cnpp_pkg::CAM_W-1:0];
				cnpp_pkg::REG_CAMERA_Y:   cam_y_q     <= cfg_data[cnpp_pkg::CAM_W-1:0];
				cnpp_pkg::REG_CLIP_LEFT:  clip_left_q <= cfg_data[cnpp_pkg::CLIP_W-1:0];
				cnpp_pkg::REG_CLIP_TOP:   clip_top_q  <= cfg_data[cnpp_pkg::CLIP_W-1:0];
				cnpp_pkg::REG_CLIP_W:     clip_w_q    <= cfg_data[cnpp_pkg::CLIP_W-1:0];
				cnpp_pkg::REG_CLIP_H:     clip_h_q    <= cfg_data[cnpp_pkg::CLIP_W-1:0];
				cnpp_pkg::REG_TRANS_MASK: mask_q      <= cfg_data[cnpp_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= cnpp_pkg::op_t'(operation);
			x_q     <= coord_x;
			y_q     <= coord_y;
			color_q <= pixel_color;
		end
	end

	// camera offset and clip edges, all signed at full width
	always_comb begin
		wx     = EXT_W'(x_q) + EXT_W'(cam_x_q);
		wy     = EXT_W'(y_q) + EXT_W'(cam_y_q);
		rx     = EXT_W'(x_q);
		ry     = EXT_W'(y_q);
		clip_l = signed'(EXT_W'(clip_left_q));
		clip_t = signed'(EXT_W'(clip_top_q));
		clip_r = signed'(EXT_W'({1'b0, clip_left_q} + {1'b0, clip_w_q}));
		clip_b = signed'(EXT_W'({1'b0, clip_top_q} + {1'b0, clip_h_q}));
		in_clip     = (wx >= clip_l) && (wy >= clip_t) && (wx < clip_r) && (wy < clip_b);
		w_on_screen = on_screen(wx, wy);
		r_on_screen = on_screen(rx, ry);
		opaque      = !mask_q[color_q];
		wr_ok       = (op_q == cnpp_pkg::OP_WRITE) && in_clip && w_on_screen && opaque;
	end

	always_comb begin
		mem_we    = cmd.fill_wr || (cmd.exec && wr_ok);
		mem_re    = cmd.exec && (op_q == cnpp_pkg::OP_READ);
		mem_wdata = cmd.fill_zero ? '0 : color_q;
		if (cmd.fill_wr) begin
			mem_addr = cnt_q;
		end else if (op_q == cnpp_pkg::OP_READ) begin
			mem_addr = pix_addr(rx, ry);
		end else begin
			mem_addr = pix_addr(wx, wy);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.fill_wr) begin
			cnt_q <= status.fill_last ? '0 : cnt_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_flag_q <= 1'b0;
			rd_hit_q  <= 1'b0;
		end else if (cmd.exec) begin
			wr_flag_q <= wr_ok || (op_q == cnpp_pkg::OP_CLEAR);
			rd_hit_q  <= (op_q == cnpp_pkg::OP_READ) && r_on_screen;
		end
	end

	assign status.is_clear  = (op_q == cnpp_pkg::OP_CLEAR);
	assign status.fill_last = (cnt_q == ADDR_W'(cnpp_pkg::STORE_DEPTH - 1));

	assign read_color  = rd_hit_q ? rd_data_q : '0;
	assign was_written = wr_flag_q;

endmodule

>>> rtl/core/clipped_nibble_pixel_plotter_top.sv
// 128x128 framebuffer of 4-bit colours with camera offset, clip rectangle and a
// per-colour transparency mask. each input transfer returns exactly one result
// transfer. pixel write and pixel read each go through accept, one memory
// access on the single-port store, and a result held until taken; a clear sweeps
// the store one pixel per cycle. after reset the block runs a clearing pass over
// the whole store with in_stall high; configuration writes are taken during that
// pass as always. configuration registers are written by index through cfg_we /
// cfg_index / cfg_data and should only change while no item is in flight.
`timescale 1ns / 1ps

module clipped_nibble_pixel_plotter_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_we,
	input  logic [cnpp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [cnpp_pkg::CFG_DATA_W-1:0]       cfg_data,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [cnpp_pkg::OP_W-1:0]             operation,
	input  logic signed [cnpp_pkg::COORD_W-1:0]   coord_x,
	input  logic signed [cnpp_pkg::COORD_W-1:0]   coord_y,
	input  logic [cnpp_pkg::COLOR_W-1:0]          pixel_color,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [cnpp_pkg::COLOR_W-1:0]          read_color,
	output logic                                  was_written
);

	// command and status between the sequencer and the datapath
	cnpp_pkg::ctrl_cmd_t  cmd;
	cnpp_pkg::dp_status_t status;

	// sequencer: reset clearing pass, accept, execute, clear sweep, result hold
	cnpp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// registers, offset and clip logic, frame store and result registers
	cnpp_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.operation   (operation),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.pixel_color (pixel_color),
		.read_color  (read_color),
		.was_written (was_written),
		.cmd         (cmd),
		.status      (status)
	);

endmodule
